### sv/ugpb_pkg.sv
// Shared constants, codes and types of the uniform grid particle binning core.
package ugpb_pkg;

  // Grid and table sizes
  localparam int MAX_GRID_LENGTH = 16;
  localparam int MAX_SLOTS       = 8;
  localparam int MAX_PARTICLES   = 1024;

  localparam int VOXELS  = MAX_GRID_LENGTH * MAX_GRID_LENGTH * MAX_GRID_LENGTH;
  localparam int VOX_W   = $clog2(VOXELS);
  localparam int GRID_W  = $clog2(MAX_GRID_LENGTH);
  localparam int SLOT_W  = $clog2(MAX_SLOTS);
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int PART_W  = $clog2(MAX_PARTICLES);
  localparam int LSQ_W   = $clog2(MAX_GRID_LENGTH * MAX_GRID_LENGTH + 1);
  localparam int STORE_W = VOX_W + SLOT_W;

  // Field widths fixed by the interface
  localparam int COORD_W = 6;
  localparam int GL_W    = 5;
  localparam int SPV_W   = 4;
  localparam int STAT_W  = 2;
  localparam int OUT_IDX_W  = 12;
  localparam int OUT_SLOT_W = 3;
  localparam int OUT_NUM_W  = 10;

  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 32;
  localparam int CFG_AW   = 1;
  localparam int CFG_DW   = 5;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_GRID_LENGTH = 1'b0;
  localparam logic [CFG_AW-1:0] REG_SLOTS       = 1'b1;

  // Commands
  localparam logic CMD_CLEAR  = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_STORED  = 2'd0,
    STAT_OUTSIDE = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_CLEARED = 2'd3
  } status_t;

  // Location of one particle in the grid
  typedef struct packed {
    logic             in_range;
    logic [VOX_W-1:0] flat;
  } vox_loc_t;

endpackage

### sv/ugpb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ugpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/ugpb_flatten.sv
// Range check of the voxel coordinates and flattening to a voxel number.
module ugpb_flatten (
  input  logic signed [ugpb_pkg::COORD_W-1:0] voxel_x,
  input  logic signed [ugpb_pkg::COORD_W-1:0] voxel_y,
  input  logic signed [ugpb_pkg::COORD_W-1:0] voxel_z,
  input  logic        [ugpb_pkg::GL_W-1:0]    len_eff,
  input  logic        [ugpb_pkg::LSQ_W-1:0]   len_sq,
  output ugpb_pkg::vox_loc_t                  loc
);
  import ugpb_pkg::*;

  logic x_ok, y_ok, z_ok;
  logic [GRID_W-1:0] x_idx, y_idx, z_idx;

  // Reject negative coordinates and those past the grid edge
  always_comb begin
    x_ok = !voxel_x[COORD_W-1] && (GL_W'(voxel_x[COORD_W-2:0]) < len_eff);
    y_ok = !voxel_y[COORD_W-1] && (GL_W'(voxel_y[COORD_W-2:0]) < len_eff);
    z_ok = !voxel_z[COORD_W-1] && (GL_W'(voxel_z[COORD_W-2:0]) < len_eff);
    x_idx = voxel_x[GRID_W-1:0];
    y_idx = voxel_y[GRID_W-1:0];
    z_idx = voxel_z[GRID_W-1:0];
  end

  // Flatten as x*L*L + y*L + z
  always_comb begin
    loc.in_range = x_ok && y_ok && z_ok;
    loc.flat     = (VOX_W'(x_idx) * VOX_W'(len_sq)) +
                   (VOX_W'(y_idx) * VOX_W'(len_eff)) +
                   VOX_W'(z_idx);
  end

endmodule

### sv/uniform_grid_particle_binning_core.sv
// Top level of the uniform grid particle binning core.
//
// Usage: items arrive on the in_ stream. in_tuser carries the command (clear
// or insert), in_tdata the signed voxel coordinates of one particle. Each
// item yields exactly one result on the out_ stream: status in out_tuser,
// voxel number, slot and running particle number in out_tdata.
// Inserts run through a two-stage read-modify-write of the voxel count
// memory (read, then update and write back), with forwarding of the count
// written while the next count is read. An insert is taken every cycle
// while in_tready is high; its result passes the update stage and the
// output register. A clear walks the count memory once, one voxel a cycle,
// over all 4096 voxels, then hands out its result; no item is taken meanwhile.
// The slot store is not swept: entries at or above a voxel's count are empty.
// After reset the same sweep runs before in_tready first rises;
// configuration writes are taken at any time through the cfg_ port.
// When out_tready is low, one result waits in the output register while the
// next insert stays in the update stage; in_tready then drops.
module uniform_grid_particle_binning_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // cfg write port
  input  logic                           cfg_we,
  input  logic [ugpb_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [ugpb_pkg::CFG_DW-1:0]    cfg_wdata,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ugpb_pkg::IN_DW-1:0]     in_tdata,   // voxel_x, voxel_y, voxel_z, zero pad
  input  logic [0:0]                     in_tuser,   // cmd
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ugpb_pkg::OUT_DW-1:0]    out_tdata,  // voxel_index, slot, particle_number, pad
  output logic [ugpb_pkg::STAT_W-1:0]    out_tuser   // status
);
  import ugpb_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT    = 4'b0001,
    ST_RUN     = 4'b0010,
    ST_SWEEP   = 4'b0100,
    ST_CLRDONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [GL_W-1:0]  grid_len_r;
  logic [SPV_W-1:0] slots_r;
  logic [GL_W-1:0]  len_eff;
  logic [GL_W-1:0]  cfg_len_eff;
  logic [SPV_W-1:0] slots_eff;
  logic [LSQ_W-1:0] len_sq_r;

  logic [VOX_W-1:0]  sweep_cnt_r, sweep_cnt_nxt;
  logic              sweep_last;
  logic [PART_W-1:0] next_num_r, next_num_nxt;

  vox_loc_t loc;
  logic     in_xfer, clr_xfer, ins_xfer;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_in_range_r;
  logic [VOX_W-1:0]  s1_flat_r;
  logic [PART_W-1:0] s1_num_r;
  logic              fwd_hit_r;
  logic [CNT_W-1:0]  fwd_val_r;

  logic [CNT_W-1:0]  cnt_rd;
  logic [CNT_W-1:0]  s1_cnt;
  logic              s1_full;
  logic              s1_adv;
  logic              s1_write;
  status_t           s1_status;

  logic              cnt_we;
  logic [VOX_W-1:0]  cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;

  logic              out_free, clr_emit;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [VOX_W-1:0]  out_index_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [PART_W-1:0] out_num_r;

  // Configuration registers; the length square follows the write at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_len_r <= GL_W'(MAX_GRID_LENGTH);
      slots_r    <= SPV_W'(MAX_SLOTS);
      len_sq_r   <= LSQ_W'(MAX_GRID_LENGTH * MAX_GRID_LENGTH);
    end else begin
      if (cfg_we && cfg_addr == REG_GRID_LENGTH) begin
        grid_len_r <= cfg_wdata[GL_W-1:0];
        len_sq_r   <= LSQ_W'(cfg_len_eff) * LSQ_W'(cfg_len_eff);
      end
      if (cfg_we && cfg_addr == REG_SLOTS) begin
        slots_r <= cfg_wdata[SPV_W-1:0];
      end
    end
  end

  // Clamp register values into their working range
  always_comb begin
    priority if (grid_len_r == '0) begin
      len_eff = GL_W'(1);
    end else if (grid_len_r > GL_W'(MAX_GRID_LENGTH)) begin
      len_eff = GL_W'(MAX_GRID_LENGTH);
    end else begin
      len_eff = grid_len_r;
    end
    priority if (cfg_wdata[GL_W-1:0] == '0) begin
      cfg_len_eff = GL_W'(1);
    end else if (cfg_wdata[GL_W-1:0] > GL_W'(MAX_GRID_LENGTH)) begin
      cfg_len_eff = GL_W'(MAX_GRID_LENGTH);
    end else begin
      cfg_len_eff = cfg_wdata[GL_W-1:0];
    end
    priority if (slots_r == '0) begin
      slots_eff = SPV_W'(1);
    end else if (slots_r > SPV_W'(MAX_SLOTS)) begin
      slots_eff = SPV_W'(MAX_SLOTS);
    end else begin
      slots_eff = slots_r;
    end
  end

  ugpb_flatten u_flatten (
    .voxel_x (in_tdata[COORD_W-1:0]),
    .voxel_y (in_tdata[2*COORD_W-1:COORD_W]),
    .voxel_z (in_tdata[3*COORD_W-1:2*COORD_W]),
    .len_eff (len_eff),
    .len_sq  (len_sq_r),
    .loc     (loc)
  );

  // Handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = (state_r == ST_RUN) && (!s1_valid_r || out_free);
  assign in_xfer   = in_tvalid && in_tready;
  assign clr_xfer  = in_xfer && (in_tuser[0] == CMD_CLEAR);
  assign ins_xfer  = in_xfer && (in_tuser[0] == CMD_INSERT);
  assign clr_emit  = (state_r == ST_CLRDONE) && out_free;
  assign sweep_last = (sweep_cnt_r == VOX_W'(VOXELS - 1));

  // Sequencer for reset and clear sweeps
  always_comb begin
    state_nxt     = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    unique case (state_r)
      ST_INIT: begin
        sweep_cnt_nxt = sweep_cnt_r + VOX_W'(1);
        if (sweep_last) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (clr_xfer) begin
          state_nxt     = ST_SWEEP;
          sweep_cnt_nxt = '0;
        end
      end
      ST_SWEEP: begin
        sweep_cnt_nxt = sweep_cnt_r + VOX_W'(1);
        if (sweep_last) begin
          state_nxt = ST_CLRDONE;
        end
      end
      ST_CLRDONE: begin
        if (out_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // Running particle number
  always_comb begin
    next_num_nxt = next_num_r;
    priority if (clr_xfer) begin
      next_num_nxt = '0;
    end else if (ins_xfer) begin
      if (next_num_r == PART_W'(MAX_PARTICLES - 1)) begin
        next_num_nxt = '0;
      end else begin
        next_num_nxt = next_num_r + PART_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_cnt_r <= '0;
      next_num_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      next_num_r  <= next_num_nxt;
    end
  end

  // Count memory write: sweep zeros or the updated count
  always_comb begin
    if (state_r == ST_INIT || state_r == ST_SWEEP) begin
      cnt_we    = 1'b1;
      cnt_waddr = sweep_cnt_r;
      cnt_wdata = '0;
    end else begin
      cnt_we    = s1_write;
      cnt_waddr = s1_flat_r;
      cnt_wdata = s1_cnt + CNT_W'(1);
    end
  end

  ugpb_ram #(
    .WIDTH (CNT_W),
    .DEPTH (VOXELS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (ins_xfer),
    .raddr (loc.flat),
    .rdata (cnt_rd)
  );

  // Slot store: entries at or past the voxel count are treated as empty
  ugpb_ram #(
    .WIDTH (PART_W),
    .DEPTH (VOXELS * MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (s1_write),
    .waddr ({s1_flat_r, s1_cnt[SLOT_W-1:0]}),
    .wdata (s1_num_r),
    .re    (1'b0),
    .raddr ('0),
    .rdata ()
  );

  // Update stage: forward the count written in the cycle of the read
  always_comb begin
    s1_cnt   = fwd_hit_r ? fwd_val_r : cnt_rd;
    s1_full  = (s1_cnt >= CNT_W'(slots_eff));
    s1_write = s1_adv && s1_in_range_r && !s1_full;
    priority if (!s1_in_range_r) begin
      s1_status = STAT_OUTSIDE;
    end else if (s1_full) begin
      s1_status = STAT_FULL;
    end else begin
      s1_status = STAT_STORED;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (ins_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture insert payload and forwarding data
  always_ff @(posedge clk) begin
    if (ins_xfer) begin
      s1_in_range_r <= loc.in_range;
      s1_flat_r     <= loc.flat;
      s1_num_r      <= next_num_r;
      fwd_hit_r     <= s1_write && (s1_flat_r == loc.flat);
      fwd_val_r     <= s1_cnt + CNT_W'(1);
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv || clr_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_emit) begin
      out_status_r <= STAT_CLEARED;
      out_index_r  <= '0;
      out_slot_r   <= '0;
      out_num_r    <= '0;
    end else if (s1_adv) begin
      out_status_r <= s1_status;
      out_index_r  <= s1_in_range_r ? s1_flat_r : '0;
      out_slot_r   <= (s1_status == STAT_STORED) ? s1_cnt[SLOT_W-1:0] : '0;
      out_num_r    <= s1_num_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DW'({OUT_NUM_W'(out_num_r), OUT_SLOT_W'(out_slot_r),
                               OUT_IDX_W'(out_index_r)});

`ifndef SYNTHESIS
  // The update stage is empty whenever a sweep runs
  a_no_insert_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !s1_valid_r)
    else $error("insert pending during count sweep");

  // A clear starts a sweep and restarts particle numbering
  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_xfer |=> (state_r == ST_SWEEP && next_num_r == '0))
    else $error("clear did not start sweep");

  // A stored particle lands below the slot limit
  a_slot_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_STORED) |-> (SPV_W'(out_slot_r) < slots_eff))
    else $error("slot beyond voxel limit");

  // Count write-back never exceeds the slot capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_we |-> (cnt_wdata <= CNT_W'(MAX_SLOTS)))
    else $error("voxel count overflow");
`endif

endmodule
